/* src/hmk_pkg.sv */
// Shared types and constants of the histogram key-point matcher.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps
`default_nettype none
package hmk_pkg;

   localparam int GRAY_W   = 16;
   localparam int KEY_W    = 24;
   localparam int PIDX_W   = 6;
   localparam int STAT_W   = 2;
   localparam int RSP_W    = 56;
   localparam int QUO_W    = 16;
   localparam int STEP_W   = 4;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [GRAY_W-1:0] min0;
      logic [GRAY_W-1:0] max0;
      logic [GRAY_W-1:0] min1;
      logic [GRAY_W-1:0] max1;
      logic              overflow;
   } stats_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_phase_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_LOAD,
      S_CHECK,
      S_EMPTY,
      S_BIN_RD,
      S_BIN_MUL,
      S_BIN_WAIT,
      S_BIN_HRD,
      S_BIN_HWR,
      S_SCAN_RD0,
      S_SCAN_C0,
      S_SCAN_NX,
      S_SCAN_EVAL,
      S_KEY_PREP,
      S_KEY_WAIT,
      S_KEY_FIX,
      S_OUT,
      S_FINISH
   } state_type;

endpackage
`default_nettype wire

/* src/hmk_muldiv.sv */
// Iterative unit for floor(a * b / c): shift-add multiply, then restoring divide.
// Depends on hmk_pkg. Quotient must fit QUO_W bits.
`timescale 1ns / 1ps
`default_nettype none
module hmk_muldiv #(
   parameter int B_W = 24,
   parameter int C_W = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [hmk_pkg::GRAY_W-1:0]  a,
   input  wire logic [B_W-1:0]              b,
   input  wire logic [C_W-1:0]              c,
   output logic                             busy,
   output logic                             done,
   output logic [hmk_pkg::QUO_W-1:0]        quo
);

   localparam int P_W = hmk_pkg::GRAY_W + B_W;
   localparam int R_W = (P_W > C_W + hmk_pkg::QUO_W) ? P_W : C_W + hmk_pkg::QUO_W;

   hmk_pkg::md_phase_type phase_ff, phase_in;
   logic [hmk_pkg::STEP_W-1:0] step_ff, step_in;
   logic [hmk_pkg::GRAY_W-1:0] mcand_ff, mcand_in;
   logic [B_W-1:0]             b_ff, b_in;
   logic [C_W-1:0]             c_ff, c_in;
   logic [R_W-1:0]             rem_ff, rem_in;
   logic [R_W-1:0]             dvs_ff, dvs_in;
   logic [hmk_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic                       done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hmk_pkg::MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      step_ff  <= step_in;
      mcand_ff <= mcand_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
   end

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      mcand_in = mcand_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      case (phase_ff)
         hmk_pkg::MD_IDLE: begin
            if (start) begin
               mcand_in = a;
               b_in     = b;
               c_in     = c;
               rem_in   = '0;
               step_in  = '0;
               phase_in = hmk_pkg::MD_MUL;
            end
         end
         hmk_pkg::MD_MUL: begin
            rem_in   = (rem_ff << 1)
                       + (mcand_ff[hmk_pkg::GRAY_W-1] ? {{(R_W-B_W){1'b0}}, b_ff} : '0);
            mcand_in = mcand_ff << 1;
            step_in  = step_ff + 1'b1;
            if (step_ff == '1) begin
               dvs_in   = {{(R_W-C_W-hmk_pkg::QUO_W+1){1'b0}}, c_ff,
                           {(hmk_pkg::QUO_W-1){1'b0}}};
               quo_in   = '0;
               phase_in = hmk_pkg::MD_DIV;
            end
         end
         hmk_pkg::MD_DIV: begin
            if (rem_ff >= dvs_ff) begin
               rem_in = rem_ff - dvs_ff;
               quo_in = {quo_ff[hmk_pkg::QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[hmk_pkg::QUO_W-2:0], 1'b0};
            end
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               done_in  = 1'b1;
               phase_in = hmk_pkg::MD_IDLE;
            end
         end
         default: phase_in = hmk_pkg::MD_IDLE;
      endcase
   end

   assign busy = (phase_ff != hmk_pkg::MD_IDLE);
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

/* src/hmk_store.sv */
// Sample buffers of both sets with counts, extremes and overflow flag.
// Depends on hmk_pkg. Synchronous write at the fill count, registered read.
`timescale 1ns / 1ps
`default_nettype none
module hmk_store #(
   parameter int MAX_SAMPLES = 4096,
   parameter int AW = 12,
   parameter int CW = 13
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic                        wr_sel,
   input  wire logic [hmk_pkg::GRAY_W-1:0]  wr_data,
   input  wire logic                        clear,
   input  wire logic [AW-1:0]               rd_addr,
   output logic [hmk_pkg::GRAY_W-1:0]       rd_data0,
   output logic [hmk_pkg::GRAY_W-1:0]       rd_data1,
   output logic [CW-1:0]                    count0,
   output logic [CW-1:0]                    count1,
   output hmk_pkg::stats_type               stats
);

   logic [hmk_pkg::GRAY_W-1:0] buf0_mem [MAX_SAMPLES];
   logic [hmk_pkg::GRAY_W-1:0] buf1_mem [MAX_SAMPLES];
   logic [CW-1:0]              cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;
   hmk_pkg::stats_type         st_ff, st_in;
   logic                       we0, we1;
   logic [hmk_pkg::GRAY_W-1:0] rd0_ff, rd1_ff;

   always_comb begin
      cnt0_in = cnt0_ff;
      cnt1_in = cnt1_ff;
      st_in   = st_ff;
      we0     = 1'b0;
      we1     = 1'b0;
      if (clear) begin
         cnt0_in = '0;
         cnt1_in = '0;
         st_in   = '{min0: '1, max0: '0, min1: '1, max1: '0, overflow: 1'b0};
      end else if (wr_en) begin
         if (!wr_sel) begin
            if (cnt0_ff == CW'(MAX_SAMPLES)) begin
               st_in.overflow = 1'b1;
            end else begin
               we0     = 1'b1;
               cnt0_in = cnt0_ff + 1'b1;
               if (wr_data < st_ff.min0) st_in.min0 = wr_data;
               if (wr_data > st_ff.max0) st_in.max0 = wr_data;
            end
         end else begin
            if (cnt1_ff == CW'(MAX_SAMPLES)) begin
               st_in.overflow = 1'b1;
            end else begin
               we1     = 1'b1;
               cnt1_in = cnt1_ff + 1'b1;
               if (wr_data < st_ff.min1) st_in.min1 = wr_data;
               if (wr_data > st_ff.max1) st_in.max1 = wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt0_ff <= '0;
         cnt1_ff <= '0;
         st_ff   <= '{min0: '1, max0: '0, min1: '1, max1: '0, overflow: 1'b0};
      end else begin
         cnt0_ff <= cnt0_in;
         cnt1_ff <= cnt1_in;
         st_ff   <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) buf0_mem[cnt0_ff[AW-1:0]] <= wr_data;
      if (we1) buf1_mem[cnt1_ff[AW-1:0]] <= wr_data;
      rd0_ff <= buf0_mem[rd_addr];
      rd1_ff <= buf1_mem[rd_addr];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;
   assign count0   = cnt0_ff;
   assign count1   = cnt1_ff;
   assign stats    = st_ff;

endmodule
`default_nettype wire

/* src/histogram_match_key_points_top.sv */
// Top level of the histogram key-point matcher: pass sequencer and histogram memories.
// Depends on hmk_pkg, hmk_store and hmk_muldiv.
// Loading: one sample word per cycle. After the last word the pass runs:
// each stored sample is binned through the shared mul/div unit, then per set the bins
// are scanned and each control point is interpolated through the same unit.
// After reset and after every run a clearing pass over all NUM_BINS bins takes no words.
// Reset is synchronous; results appear through a one-word output register.
`timescale 1ns / 1ps
`default_nettype none
module histogram_match_key_points_top #(
   parameter int NUM_BINS    = 300,
   parameter int NUM_POINTS  = 16,
   parameter int MAX_SAMPLES = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [15:0]                req_tdata,  // gray_sample
   input  wire logic [0:0]                 req_tuser,  // set_select
   input  wire logic                       req_tlast,  // final_sample
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [hmk_pkg::RSP_W-1:0]       rsp_tdata,  // point_index, key_gray_first,
                                                       // key_gray_second, status
   output logic                            rsp_tlast   // last_point
);

   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int BW   = $clog2(NUM_BINS);
   localparam int PIW  = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
   localparam int TW   = CW + $clog2(NUM_POINTS + 2);
   localparam int NBW  = $clog2(NUM_BINS + 1);
   localparam int NMW  = TW + BW;
   localparam int DVW0 = TW + NBW;
   localparam int DVW  = (DVW0 > 16) ? DVW0 : 16;
   localparam int KW   = hmk_pkg::GRAY_W + 1;
   localparam logic [TW-1:0]  P1_T    = TW'(NUM_POINTS + 1);
   localparam logic [BW-1:0]  BIN_TOP = BW'(NUM_BINS - 1);
   localparam logic [PIW-1:0] PT_TOP  = PIW'(NUM_POINTS - 1);

   hmk_pkg::state_type state_ff, state_in;
   logic              set_ff, set_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [BW-1:0]     j_ff, j_in;
   logic [PIW-1:0]    pt_ff, pt_in;
   logic [CW-1:0]     cur_ff, cur_in, nxt_ff, nxt_in;
   logic [15:0]       lo_ff, lo_in, rng_ff, rng_in;
   logic [BW-1:0]     bin_ff, bin_in, clr_ff, clr_in;
   logic [TW-1:0]     den_ff, den_in, f_ff, f_in;
   logic [KW-1:0]     key_ff, key_in;
   logic              rv_ff, rv_in, rl_ff, rl_in;
   logic [hmk_pkg::RSP_W-1:0] rd_ff, rd_in;

   logic [CW-1:0] hist0_mem [NUM_BINS];
   logic [CW-1:0] hist1_mem [NUM_BINS];
   logic [KW-1:0] key_mem [NUM_POINTS];
   logic [CW-1:0] hq0_ff, hq1_ff;
   logic [KW-1:0] keyq_ff;
   logic [BW-1:0] hist_ra, hist_wa;
   logic [CW-1:0] hist_wd;
   logic          hist_we0, hist_we1, key_we;

   logic                      st_wr, st_clear;
   logic [hmk_pkg::GRAY_W-1:0] st_rd0, st_rd1;
   logic [CW-1:0]             cnt0, cnt1;
   hmk_pkg::stats_type        stats;

   logic                      md_start, md_busy, md_done;
   logic [15:0]               md_a;
   logic [NMW-1:0]            md_b;
   logic [DVW-1:0]            md_c;
   logic [hmk_pkg::QUO_W-1:0] md_q;

   logic [CW-1:0]  cnt_s, hq_s;
   logic [15:0]    mn_s, mx_s, smp_s;
   logic [TW-1:0]  target, cp, np;
   logic [KW-1:0]  key_fix;

   hmk_store #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW), .CW(CW)) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (st_wr),
      .wr_sel   (req_tuser[0]),
      .wr_data  (req_tdata),
      .clear    (st_clear),
      .rd_addr  (k_ff[AW-1:0]),
      .rd_data0 (st_rd0),
      .rd_data1 (st_rd1),
      .count0   (cnt0),
      .count1   (cnt1),
      .stats    (stats)
   );

   hmk_muldiv #(.B_W(NMW), .C_W(DVW)) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (md_a),
      .b     (md_b),
      .c     (md_c),
      .busy  (md_busy),
      .done  (md_done),
      .quo   (md_q)
   );

   assign cnt_s  = set_ff ? cnt1 : cnt0;
   assign hq_s   = set_ff ? hq1_ff : hq0_ff;
   assign mn_s   = set_ff ? stats.min1 : stats.min0;
   assign mx_s   = set_ff ? stats.max1 : stats.max0;
   assign smp_s  = set_ff ? st_rd1 : st_rd0;
   assign target = (TW'(pt_ff) + TW'(1)) * TW'(cnt_s);
   assign cp     = TW'(cur_ff) * P1_T;
   assign np     = TW'(nxt_ff) * P1_T;

   always_comb begin
      key_fix = key_ff;
      if (pt_ff == '0 && key_fix < KW'(mn_s)) key_fix = KW'(mn_s);
      if (pt_ff == PT_TOP && key_fix > KW'(mx_s)) key_fix = KW'(mx_s);
   end

   always_comb begin
      state_in = state_ff;
      set_in   = set_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      pt_in    = pt_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      lo_in    = lo_ff;
      rng_in   = rng_ff;
      bin_in   = bin_ff;
      clr_in   = clr_ff;
      den_in   = den_ff;
      f_in     = f_ff;
      key_in   = key_ff;
      rv_in    = rv_ff && !rsp_tready;
      rl_in    = rl_ff;
      rd_in    = rd_ff;
      req_tready = 1'b0;
      st_wr    = 1'b0;
      st_clear = 1'b0;
      md_start = 1'b0;
      md_a     = rng_ff;
      md_b     = NMW'(j_ff) * NMW'(den_ff) + NMW'(f_ff);
      md_c     = DVW'(den_ff) * DVW'(NUM_BINS);
      hist_ra  = j_ff;
      hist_wa  = bin_ff;
      hist_wd  = hq_s + 1'b1;
      hist_we0 = 1'b0;
      hist_we1 = 1'b0;
      key_we   = 1'b0;
      case (state_ff)
         hmk_pkg::S_CLEAR: begin
            hist_wa  = clr_ff;
            hist_wd  = '0;
            hist_we0 = 1'b1;
            hist_we1 = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == BIN_TOP) state_in = hmk_pkg::S_LOAD;
         end
         hmk_pkg::S_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               st_wr = 1'b1;
               if (req_tlast) state_in = hmk_pkg::S_CHECK;
            end
         end
         hmk_pkg::S_CHECK: begin
            lo_in  = (stats.min0 < stats.min1) ? stats.min0 : stats.min1;
            rng_in = ((stats.max0 > stats.max1) ? stats.max0 : stats.max1) - lo_in;
            set_in = 1'b0;
            k_in   = '0;
            if (cnt0 == '0 || cnt1 == '0) state_in = hmk_pkg::S_EMPTY;
            else                          state_in = hmk_pkg::S_BIN_RD;
         end
         hmk_pkg::S_EMPTY: begin
            if (!rv_ff) begin
               rv_in    = 1'b1;
               rl_in    = 1'b1;
               rd_in    = {hmk_pkg::STAT_EMPTY, {(hmk_pkg::RSP_W-hmk_pkg::STAT_W){1'b0}}};
               state_in = hmk_pkg::S_FINISH;
            end
         end
         hmk_pkg::S_BIN_RD: state_in = hmk_pkg::S_BIN_MUL;
         hmk_pkg::S_BIN_MUL: begin
            md_a = smp_s - lo_ff;
            md_b = NMW'(NUM_BINS);
            md_c = DVW'(rng_ff);
            if (rng_ff == '0) begin
               bin_in   = '0;
               state_in = hmk_pkg::S_BIN_HRD;
            end else begin
               md_start = 1'b1;
               state_in = hmk_pkg::S_BIN_WAIT;
            end
         end
         hmk_pkg::S_BIN_WAIT: begin
            if (md_done) begin
               bin_in   = (md_q > hmk_pkg::QUO_W'(NUM_BINS - 1)) ? BIN_TOP : md_q[BW-1:0];
               state_in = hmk_pkg::S_BIN_HRD;
            end
         end
         hmk_pkg::S_BIN_HRD: begin
            hist_ra  = bin_ff;
            state_in = hmk_pkg::S_BIN_HWR;
         end
         hmk_pkg::S_BIN_HWR: begin
            hist_we0 = !set_ff;
            hist_we1 = set_ff;
            k_in     = k_ff + 1'b1;
            state_in = hmk_pkg::S_BIN_RD;
            if (k_in == cnt_s) begin
               k_in = '0;
               if (!set_ff) begin
                  set_in = 1'b1;
               end else begin
                  set_in   = 1'b0;
                  j_in     = '0;
                  pt_in    = '0;
                  state_in = hmk_pkg::S_SCAN_RD0;
               end
            end
         end
         hmk_pkg::S_SCAN_RD0: begin
            hist_ra  = '0;
            state_in = hmk_pkg::S_SCAN_C0;
         end
         hmk_pkg::S_SCAN_C0: begin
            cur_in   = hq_s;
            hist_ra  = BW'(1);
            state_in = hmk_pkg::S_SCAN_NX;
         end
         hmk_pkg::S_SCAN_NX: begin
            nxt_in   = cur_ff + hq_s;
            state_in = hmk_pkg::S_SCAN_EVAL;
         end
         hmk_pkg::S_SCAN_EVAL: begin
            if (cp > target) begin
               key_in   = KW'(lo_ff);
               state_in = hmk_pkg::S_KEY_FIX;
            end else if (target < np) begin
               den_in   = np - cp;
               f_in     = target - cp;
               state_in = hmk_pkg::S_KEY_PREP;
            end else begin
               j_in     = j_ff + 1'b1;
               cur_in   = nxt_ff;
               hist_ra  = j_ff + BW'(2);
               state_in = hmk_pkg::S_SCAN_NX;
            end
         end
         hmk_pkg::S_KEY_PREP: begin
            md_start = 1'b1;
            state_in = hmk_pkg::S_KEY_WAIT;
         end
         hmk_pkg::S_KEY_WAIT: begin
            if (md_done) begin
               key_in   = KW'(lo_ff) + KW'(md_q);
               state_in = hmk_pkg::S_KEY_FIX;
            end
         end
         hmk_pkg::S_KEY_FIX: begin
            key_in = key_fix;
            if (!set_ff) begin
               key_we = 1'b1;
               if (pt_ff == PT_TOP) begin
                  set_in   = 1'b1;
                  pt_in    = '0;
                  j_in     = '0;
                  state_in = hmk_pkg::S_SCAN_RD0;
               end else begin
                  pt_in    = pt_ff + 1'b1;
                  state_in = hmk_pkg::S_SCAN_EVAL;
               end
            end else begin
               state_in = hmk_pkg::S_OUT;
            end
         end
         hmk_pkg::S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               rl_in = (pt_ff == PT_TOP);
               rd_in = {stats.overflow ? hmk_pkg::STAT_OVERFLOW : hmk_pkg::STAT_OK,
                        hmk_pkg::KEY_W'(key_ff), hmk_pkg::KEY_W'(keyq_ff),
                        hmk_pkg::PIDX_W'(pt_ff)};
               if (pt_ff == PT_TOP) begin
                  state_in = hmk_pkg::S_FINISH;
               end else begin
                  pt_in    = pt_ff + 1'b1;
                  state_in = hmk_pkg::S_SCAN_EVAL;
               end
            end
         end
         hmk_pkg::S_FINISH: begin
            st_clear = 1'b1;
            set_in   = 1'b0;
            clr_in   = '0;
            state_in = hmk_pkg::S_CLEAR;
         end
         default: state_in = hmk_pkg::S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmk_pkg::S_CLEAR;
         clr_ff   <= '0;
         set_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         set_ff   <= set_in;
         rv_ff    <= rv_in;
      end
      k_ff   <= k_in;
      j_ff   <= j_in;
      pt_ff  <= pt_in;
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      lo_ff  <= lo_in;
      rng_ff <= rng_in;
      bin_ff <= bin_in;
      den_ff <= den_in;
      f_ff   <= f_in;
      key_ff <= key_in;
      rl_ff  <= rl_in;
      rd_ff  <= rd_in;
   end

   always_ff @(posedge clock) begin
      if (hist_we0) hist0_mem[hist_wa] <= hist_wd;
      if (hist_we1) hist1_mem[hist_wa] <= hist_wd;
      if (key_we)   key_mem[pt_ff]     <= key_fix;
      hq0_ff  <= hist0_mem[hist_ra];
      hq1_ff  <= hist1_mem[hist_ra];
      keyq_ff <= key_mem[pt_ff];
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;

   a_no_load_in_pass: assert property (@(posedge clock) disable iff (reset)
      md_busy |-> !req_tready) else $error("word taken while pass busy");
   a_hist_write_when: assert property (@(posedge clock) disable iff (reset)
      (hist_we0 || hist_we1) |->
         (state_ff == hmk_pkg::S_BIN_HWR || state_ff == hmk_pkg::S_CLEAR))
      else $error("histogram written outside binning or clearing");
   a_md_done_waited: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == hmk_pkg::S_BIN_WAIT || state_ff == hmk_pkg::S_KEY_WAIT))
      else $error("mul/div result not awaited");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[55:54] == hmk_pkg::STAT_OK
                   || rsp_tdata[55:54] == hmk_pkg::STAT_EMPTY
                   || rsp_tdata[55:54] == hmk_pkg::STAT_OVERFLOW))
      else $error("bad status code");

endmodule
`default_nettype wire

/* test/hmk_checker.sv */
// Checker for the histogram key-point matcher: watches both streams, predicts the
// control points of each run and compares them word by word. Depends on hmk_pkg.
`timescale 1ns / 1ps
module hmk_checker #(
   parameter int NUM_BINS    = 300,
   parameter int NUM_POINTS  = 16,
   parameter int MAX_SAMPLES = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   input  wire logic [15:0]              req_tdata,
   input  wire logic [0:0]               req_tuser,
   input  wire logic                     req_tlast,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic [hmk_pkg::RSP_W-1:0] rsp_tdata,
   input  wire logic                     rsp_tlast,
   output int                            failures,
   output int                            pending,
   output int                            points_seen
);

   typedef struct {
      logic [hmk_pkg::PIDX_W-1:0] pidx;
      logic [hmk_pkg::KEY_W-1:0]  key0;
      logic [hmk_pkg::KEY_W-1:0]  key1;
      logic [hmk_pkg::STAT_W-1:0] stat;
      logic                       last;
   } point_type;

   point_type    points_q[$];
   logic [15:0]  samples0[MAX_SAMPLES];
   logic [15:0]  samples1[MAX_SAMPLES];
   int unsigned  hist0[NUM_BINS];
   int unsigned  hist1[NUM_BINS];
   int unsigned  count0, count1;
   logic [15:0]  min0, max0, min1, max1;
   logic         dropped;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      failures++;
      $display("%t  point word: %s got %0h, wanted %0h", $realtime, what, got, want);
   endtask

   function automatic longint unsigned key_at(input int unsigned h[NUM_BINS],
                                              input int unsigned n, input int unsigned i,
                                              input int unsigned lo, input int unsigned range);
      longint unsigned p1, target, cur, nxt, den, num;
      p1 = NUM_POINTS + 1;
      target = (longint'(i) + 1) * n;
      cur = h[0];
      for (int j = 0; j + 1 < NUM_BINS; j++) begin
         nxt = cur + h[j+1];
         if (cur * p1 <= target && target < nxt * p1) begin
            den = (nxt - cur) * p1;
            num = longint'(j) * den + (target - cur * p1);
            return longint'(lo) + (longint'(range) * num) / (den * NUM_BINS);
         end
         cur = nxt;
      end
      return longint'(lo);
   endfunction

   task automatic clear_run();
      count0 = 0; count1 = 0;
      min0 = 16'hFFFF; max0 = 0; min1 = 16'hFFFF; max1 = 0;
      dropped = 0;
   endtask

   task automatic predict_points();
      int unsigned lo, hi, range, b;
      longint unsigned k0, k1, q;
      point_type p;
      if (count0 == 0 || count1 == 0) begin
         p = '{pidx: 0, key0: 0, key1: 0, stat: hmk_pkg::STAT_EMPTY, last: 1'b1};
         points_q = {points_q, p};
         return;
      end
      lo = (min0 < min1) ? min0 : min1;
      hi = (max0 > max1) ? max0 : max1;
      range = hi - lo;
      foreach (hist0[j]) begin
         hist0[j] = 0; hist1[j] = 0;
      end
      for (int k = 0; k < count0; k++) begin
         b = 0;
         if (range != 0) begin
            q = longint'(samples0[k] - lo) * NUM_BINS / range;
            b = (q > NUM_BINS - 1) ? NUM_BINS - 1 : int'(q);
         end
         hist0[b]++;
      end
      for (int k = 0; k < count1; k++) begin
         b = 0;
         if (range != 0) begin
            q = longint'(samples1[k] - lo) * NUM_BINS / range;
            b = (q > NUM_BINS - 1) ? NUM_BINS - 1 : int'(q);
         end
         hist1[b]++;
      end
      for (int i = 0; i < NUM_POINTS; i++) begin
         k0 = key_at(hist0, count0, i, lo, range);
         k1 = key_at(hist1, count1, i, lo, range);
         if (i == 0) begin
            if (k0 < min0) k0 = min0;
            if (k1 < min1) k1 = min1;
         end
         if (i == NUM_POINTS - 1) begin
            if (k0 > max0) k0 = max0;
            if (k1 > max1) k1 = max1;
         end
         p.pidx = hmk_pkg::PIDX_W'(i);
         p.key0 = k0[hmk_pkg::KEY_W-1:0];
         p.key1 = k1[hmk_pkg::KEY_W-1:0];
         p.stat = dropped ? hmk_pkg::STAT_OVERFLOW : hmk_pkg::STAT_OK;
         p.last = (i == NUM_POINTS - 1);
         points_q = {points_q, p};
      end
   endtask

   initial begin
      failures = 0;
      points_seen = 0;
      clear_run();
   end

   // Inputs change only just after rising edges, so the falling edge sees what the
   // next rising edge will accept.
   always @(negedge clock) begin
      point_type w;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == 1'b0) begin
               if (count0 >= MAX_SAMPLES) dropped = 1;
               else begin
                  samples0[count0] = req_tdata;
                  count0++;
                  if (req_tdata < min0) min0 = req_tdata;
                  if (req_tdata > max0) max0 = req_tdata;
               end
            end else begin
               if (count1 >= MAX_SAMPLES) dropped = 1;
               else begin
                  samples1[count1] = req_tdata;
                  count1++;
                  if (req_tdata < min1) min1 = req_tdata;
                  if (req_tdata > max1) max1 = req_tdata;
               end
            end
            if (req_tlast) begin
               predict_points();
               clear_run();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            points_seen++;
            if (points_q.size() == 0) begin
               report("unexpected word", rsp_tdata, 0);
            end else begin
               w = points_q.pop_front();
               if (rsp_tdata[5:0] !== w.pidx) report("point_index", rsp_tdata[5:0], w.pidx);
               if (rsp_tdata[29:6] !== w.key0)
                  report("key_gray_first", rsp_tdata[29:6], w.key0);
               if (rsp_tdata[53:30] !== w.key1)
                  report("key_gray_second", rsp_tdata[53:30], w.key1);
               if (rsp_tdata[55:54] !== w.stat) report("status", rsp_tdata[55:54], w.stat);
               if (rsp_tlast !== w.last) report("last_point", rsp_tlast, w.last);
            end
         end
      end
      pending = points_q.size();
   end
endmodule

/* test/tb_histogram_match_key_points_top.sv */
// Testbench top of the histogram key-point matcher: clock, reset, sample stimulus,
// receiver back-pressure and verdict. Depends on hmk_pkg, hmk_checker and the block.
`timescale 1ns / 1ps
module tb_histogram_match_key_points_top;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int ITEMS       = 410;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [15:0]         req_tdata = 0;   // gray_sample
   logic [0:0]          req_tuser = 0;   // set_select
   logic                req_tlast = 0;   // final_sample
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [hmk_pkg::RSP_W-1:0] rsp_tdata; // point_index, key_gray_first, key_gray_second, status
   logic                rsp_tlast;       // last_point
   int                  failures, pending, points_seen;
   int                  words_sent = 0, runs_sent = 0, cycles = 0;
   bit                  no_gaps = 0, hold_off = 0;
   int                  gray_mode;
   logic [15:0]         gray_base, gray_span;

   histogram_match_key_points_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   hmk_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .failures(failures), .pending(pending), .points_seen(points_seen)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("cycle limit reached");
         $display("histogram_match_key_points_top: mismatch");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] next_gray();
      if (gray_mode == 0) return 16'($urandom);
      if (gray_mode == 1) return 16'(gray_base + $urandom_range(0, gray_span));
      return gray_base;
   endfunction

   task automatic send_word(input logic sel, input logic [15:0] gray, input logic fin);
      bit taken;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= sel;
      req_tdata  <= gray;
      req_tlast  <= fin;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      words_sent++;
      if (fin) runs_sent++;
      gap = no_gaps ? 0 : gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_run(input int n0, input int n1);
      int left0, left1;
      logic sel;
      left0 = n0;
      left1 = n1;
      while (left0 + left1 > 0) begin
         if (left0 == 0) sel = 1;
         else if (left1 == 0) sel = 0;
         else sel = 1'($urandom_range(0, 1));
         if (sel) left1--; else left0--;
         send_word(sel, next_gray(), (left0 + left1 == 0));
      end
   endtask

   task automatic pick_mode();
      int r;
      r = $urandom_range(0, 9);
      gray_mode = (r < 5) ? 0 : (r < 9) ? 1 : 2;
      gray_span = 16'(1 << $urandom_range(0, 14));
      gray_base = 16'($urandom_range(0, 16'hFFFF - gray_span));
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (6000) @(posedge clock);
            hold_off = 0;
         end
         stall = gap_length();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 60)) @(posedge clock);
      end
   end

   initial begin
      int settle;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, zero range, empty sets, single samples
      send_word(0, 16'h0000, 0);
      send_word(1, 16'hFFFF, 1);
      send_word(1, 16'h0000, 0);
      send_word(0, 16'hFFFF, 1);
      send_word(0, 16'h1234, 0);
      send_word(1, 16'h1234, 0);
      send_word(0, 16'h1234, 1);
      send_word(0, 16'h00FF, 1);
      send_word(1, 16'hFF00, 1);
      send_word(0, 16'h5555, 0);
      send_word(0, 16'hAAAA, 0);
      send_word(1, 16'h8000, 0);
      send_word(1, 16'h7FFF, 1);
      send_word(0, 16'h0001, 0);
      send_word(1, 16'h0002, 0);
      send_word(0, 16'h0003, 0);
      send_word(1, 16'hFFFE, 1);

      // one run of words back to back
      no_gaps = 1;
      gray_mode = 0;
      send_run(20, 20);
      no_gaps = 0;

      while (words_sent < ITEMS) begin
         pick_mode();
         if (runs_sent == 12) hold_off = 1;
         if ($urandom_range(0, 15) == 0) send_run($urandom_range(0, 3), 0);
         else if ($urandom_range(0, 15) == 0) send_run(0, $urandom_range(1, 3));
         else send_run($urandom_range(1, 30), $urandom_range(1, 30));
      end

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (pending != 0) @(posedge clock);
      settle = 0;
      while (settle < 2000) begin
         @(posedge clock);
         settle++;
      end
      $display("sent %0d sample words in %0d runs, %0d control point words checked",
               words_sent, runs_sent, points_seen);
      $display("covered extremes, zero range, empty sets, back-to-back words and a long hold-off");
      if (failures == 0 && pending == 0) begin
         $display("histogram_match_key_points_top: match");
      end else begin
         $display("histogram_match_key_points_top: mismatch");
      end
      $finish;
   end

endmodule

/* histogram_match_key_points_top.f */
src/hmk_pkg.sv
src/hmk_muldiv.sv
src/hmk_store.sv
src/histogram_match_key_points_top.sv
test/hmk_checker.sv
test/tb_histogram_match_key_points_top.sv
